// File: rtl/affine_bilinear_sampler_macros.svh
// Assertion macros shared by the affine bilinear sampler RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef AFFINE_BILINEAR_SAMPLER_MACROS_SVH
`define AFFINE_BILINEAR_SAMPLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ABS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ABS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition must never be seen out of reset.
`define ABS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: rtl/abs_pkg.sv
`timescale 1ns / 1ps
// Affine bilinear sampler: shared types, constants and helper functions.
// No dependencies; imported by every module of the block but abs_ram.
package abs_pkg;

    localparam int STORE_BITS  = 20;
    localparam int STORE_DEPTH = 1 << STORE_BITS;
    localparam int PIX_BITS    = 24;
    localparam int DIM_BITS    = 11;
    localparam int WT_BITS     = 17;
    localparam int ACC_BITS    = 24;
    localparam int N_NEIGH     = 4;
    localparam int BEAT_BITS   = $clog2(N_NEIGH);
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_BITS   = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS    = $clog2(FIFO_DEPTH + 1);

    localparam logic [DIM_BITS-1:0] MAX_WIDTH  = 11'd1024;
    localparam logic [DIM_BITS-1:0] MAX_HEIGHT = 11'd1024;

    localparam logic [ACC_BITS-1:0] ROUND_HALF   = 24'd32768;
    localparam logic [15:0]         QUANT_OFFSET = 16'd32768;
    localparam logic [21:0]         Q14_BIAS     = 22'd127;
    // ceil(2^30 / 255): exact floor division by 255 for operands below 2^22
    localparam logic [22:0]         RECIP_255    = 23'd4210753;
    localparam int                  RECIP_SHIFT  = 30;
    localparam logic [8:0]          WT_ONE       = 9'd256;

    typedef enum logic {
        FUNC_WRITE  = 1'b0,
        FUNC_SAMPLE = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X     = 3'd0,
        CFG_ORIGIN_Y     = 3'd1,
        CFG_STEP_COS     = 3'd2,
        CFG_STEP_SIN     = 3'd3,
        CFG_FRAME_WIDTH  = 3'd4,
        CFG_FRAME_HEIGHT = 3'd5,
        CFG_QUANT_MODE   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_func       func;
        logic [19:0] pixel_addr;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [7:0]  out_x;
        logic [7:0]  out_y;
    } t_in;

    typedef struct packed {
        logic signed [15:0] chan_red;
        logic signed [15:0] chan_green;
        logic signed [15:0] chan_blue;
    } t_out;

    typedef struct packed {
        logic [31:0]         origin_x;
        logic [31:0]         origin_y;
        logic [31:0]         step_cos;
        logic [31:0]         step_sin;
        logic [DIM_BITS-1:0] frame_width;
        logic [DIM_BITS-1:0] frame_height;
        logic                quant_mode;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        origin_x:     32'd0,
        origin_y:     32'd0,
        step_cos:     32'd65536,
        step_sin:     32'd0,
        frame_width:  11'd1024,
        frame_height: 11'd1024,
        quant_mode:   1'b0
    };

    // One memory operation: a pixel write, or a sample with its four neighbours.
    // For a sample, addr is the top-left neighbour's store index.
    typedef struct packed {
        t_func                           func;
        logic [STORE_BITS-1:0]           addr;
        logic [PIX_BITS-1:0]             pixel;
        logic [N_NEIGH-1:0][WT_BITS-1:0] wt;
        logic [N_NEIGH-1:0]              in_frame;
    } t_op;

    // Travels alongside each read so the accumulator knows what the data is.
    typedef struct packed {
        logic               valid;
        logic               first;
        logic               last;
        logic               in_frame;
        logic [WT_BITS-1:0] wt;
    } t_tag;

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                      input logic [DIM_BITS-1:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic logic [15:0] quantize(input logic [7:0] v, input logic mode);
        logic [21:0] x;
        logic [44:0] p;
        x = {v, 14'd0} + Q14_BIAS;
        p = {23'd0, x} * {22'd0, RECIP_255};
        if (mode) begin
            return 16'(p[44:RECIP_SHIFT]);
        end else begin
            return {v, v} - QUANT_OFFSET;
        end
    endfunction

endpackage

// File: rtl/abs_ram.sv
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with registered read data.
// No dependencies; used for the frame store.
module abs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/abs_xform.sv
`timescale 1ns / 1ps
// Request front end: affine source position, weights, in-frame flags and
// neighbour base address over four stages. Depends on abs_pkg.
module abs_xform
    import abs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_req,
    output logic o_op_valid,
    input  logic i_op_ready,
    output t_op  o_op
);

    logic r1_v, r2_v, r3_v, r4_v;
    logic rdy1, rdy2, rdy3, rdy4;

    t_in         r1_req, r2_req, r3_req;
    logic [31:0] r1_pxc, r1_pys, r1_pxs, r1_pyc;
    logic [31:0] r2_sx, r2_sy;
    logic [STORE_BITS-1:0]           r3_row0;
    logic signed [15:0]              r3_x0;
    logic [N_NEIGH-1:0][WT_BITS-1:0] r3_wt;
    logic [N_NEIGH-1:0]              r3_inside;
    t_op         r4_op;

    logic [39:0] m_xc, m_ys, m_xs, m_yc;

    logic signed [15:0]   x0, y0;
    logic [7:0]           fx, fy;
    logic [8:0]           gx, gy;
    logic [17:0]          p00, p10, p01, p11;
    logic [DIM_BITS-1:0]  wc, hc;
    logic signed [16:0]   xs, xp, ys, yp, wls, hls;
    logic                 in_x0, in_x1, in_y0, in_y1;
    logic [STORE_BITS-1:0] y20;
    logic [30:0]          row_p;
    logic [N_NEIGH-1:0][WT_BITS-1:0] n_wt;
    logic [N_NEIGH-1:0]   n_inside;
    t_op                  n_op;

    // Each stage moves when the one after it is empty or moving.
    assign rdy4       = !r4_v || i_op_ready;
    assign rdy3       = !r3_v || rdy4;
    assign rdy2       = !r2_v || rdy3;
    assign rdy1       = !r1_v || rdy2;
    assign o_in_stall = !rdy1;

    // Stage 1: coordinate by step products, low 32 bits only.
    assign m_xc = {32'd0, i_req.out_x} * {8'd0, i_cfg.step_cos};
    assign m_ys = {32'd0, i_req.out_y} * {8'd0, i_cfg.step_sin};
    assign m_xs = {32'd0, i_req.out_x} * {8'd0, i_cfg.step_sin};
    assign m_yc = {32'd0, i_req.out_y} * {8'd0, i_cfg.step_cos};

    // Stage 3: split position, weights and bounds.
    always_comb begin
        x0  = r2_sx[31:16];
        y0  = r2_sy[31:16];
        fx  = r2_sx[15:8];
        fy  = r2_sy[15:8];
        gx  = WT_ONE - {1'b0, fx};
        gy  = WT_ONE - {1'b0, fy};
        p00 = {9'd0, gx} * {9'd0, gy};
        p10 = {10'd0, fx} * {9'd0, gy};
        p01 = {9'd0, gx} * {10'd0, fy};
        p11 = {10'd0, fx} * {10'd0, fy};
        n_wt[0] = p00[WT_BITS-1:0];
        n_wt[1] = p10[WT_BITS-1:0];
        n_wt[2] = p01[WT_BITS-1:0];
        n_wt[3] = p11[WT_BITS-1:0];

        wc  = clamp_dim(i_cfg.frame_width, MAX_WIDTH);
        hc  = clamp_dim(i_cfg.frame_height, MAX_HEIGHT);
        wls = {{(17 - DIM_BITS){1'b0}}, wc};
        hls = {{(17 - DIM_BITS){1'b0}}, hc};
        xs  = {x0[15], x0};
        ys  = {y0[15], y0};
        xp  = xs + 17'sd1;
        yp  = ys + 17'sd1;
        in_x0 = (xs >= 17'sd0) && (xs < wls);
        in_x1 = (xp >= 17'sd0) && (xp < wls);
        in_y0 = (ys >= 17'sd0) && (ys < hls);
        in_y1 = (yp >= 17'sd0) && (yp < hls);
        n_inside[0] = in_x0 && in_y0;
        n_inside[1] = in_x1 && in_y0;
        n_inside[2] = in_x0 && in_y1;
        n_inside[3] = in_x1 && in_y1;

        // Row start modulo the store size; a row of minus one still lands right
        // once the width is added back for the lower neighbours.
        y20   = {{(STORE_BITS - 16){y0[15]}}, y0};
        row_p = {{(31 - STORE_BITS){1'b0}}, y20} * {{(31 - DIM_BITS){1'b0}}, wc};
    end

    // Stage 4: assemble the memory operation.
    always_comb begin
        n_op.func     = r3_req.func;
        n_op.pixel    = {r3_req.red_in, r3_req.green_in, r3_req.blue_in};
        n_op.wt       = r3_wt;
        n_op.in_frame = r3_inside;
        if (r3_req.func == FUNC_WRITE) begin
            n_op.addr = r3_req.pixel_addr;
        end else begin
            n_op.addr = r3_row0 + {{(STORE_BITS - 16){r3_x0[15]}}, r3_x0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (rdy1) begin
                r1_v <= i_in_valid;
            end
            if (rdy2) begin
                r2_v <= r1_v;
            end
            if (rdy3) begin
                r3_v <= r2_v;
            end
            if (rdy4) begin
                r4_v <= r3_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_req <= i_req;
            r1_pxc <= m_xc[31:0];
            r1_pys <= m_ys[31:0];
            r1_pxs <= m_xs[31:0];
            r1_pyc <= m_yc[31:0];
        end
        if (rdy2) begin
            r2_req <= r1_req;
            r2_sx  <= i_cfg.origin_x + r1_pxc - r1_pys;
            r2_sy  <= i_cfg.origin_y + r1_pxs + r1_pyc;
        end
        if (rdy3) begin
            r3_req    <= r2_req;
            r3_row0   <= row_p[STORE_BITS-1:0];
            r3_x0     <= x0;
            r3_wt     <= n_wt;
            r3_inside <= n_inside;
        end
        if (rdy4) begin
            r4_op <= n_op;
        end
    end

    assign o_op_valid = r4_v;
    assign o_op       = r4_op;

endmodule

// File: rtl/abs_fetch.sv
`timescale 1ns / 1ps
// Frame memory sequencer: one write per pixel write, four neighbour reads per
// sample, each read tagged for the accumulator. Depends on abs_pkg.
`include "affine_bilinear_sampler_macros.svh"
module abs_fetch
    import abs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_op_valid,
    output logic                  o_op_ready,
    input  t_op                   i_op,
    input  logic                  i_credit_ok,
    output logic                  o_start,
    output logic                  o_ram_we,
    output logic [STORE_BITS-1:0] o_ram_addr,
    output logic [PIX_BITS-1:0]   o_ram_wdata,
    output t_tag                  o_tag
);

    logic                 r_busy;
    t_op                  r_op;
    logic [BEAT_BITS-1:0] r_beat;
    logic                 r_tag_v;
    logic                 r_tag_first;
    logic                 r_tag_last;
    logic                 r_tag_inside;
    logic [WT_BITS-1:0]   r_tag_wt;

    logic                  is_write;
    logic                  issue;
    logic                  last;
    logic [STORE_BITS-1:0] row_off;
    logic [STORE_BITS-1:0] w20;

    assign is_write = (r_op.func == FUNC_WRITE);
    // A sample starts only with a result slot reserved downstream.
    assign o_start  = r_busy && !is_write && (r_beat == '0) && i_credit_ok;
    assign issue    = r_busy && (is_write || (r_beat != '0) || i_credit_ok);
    assign last     = is_write || (r_beat == BEAT_BITS'(N_NEIGH - 1));
    assign o_op_ready = !r_busy || (issue && last);

    assign w20     = {{(STORE_BITS - DIM_BITS){1'b0}}, clamp_dim(i_cfg.frame_width, MAX_WIDTH)};
    assign row_off = r_beat[1] ? w20 : '0;

    assign o_ram_we    = issue && is_write;
    assign o_ram_wdata = r_op.pixel;
    assign o_ram_addr  = is_write ? r_op.addr
                                  : r_op.addr + row_off + {{(STORE_BITS - 1){1'b0}}, r_beat[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_beat  <= '0;
            r_tag_v <= 1'b0;
        end else begin
            if (o_op_ready) begin
                r_busy <= i_op_valid;
            end
            if (issue) begin
                r_beat <= last ? '0 : r_beat + 1'b1;
            end
            r_tag_v <= issue && !is_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_op_ready && i_op_valid) begin
            r_op <= i_op;
        end
        r_tag_first  <= (r_beat == '0);
        r_tag_last   <= last;
        r_tag_inside <= r_op.in_frame[r_beat];
        r_tag_wt     <= r_op.wt[r_beat];
    end

    assign o_tag.valid    = r_tag_v;
    assign o_tag.first    = r_tag_first;
    assign o_tag.last     = r_tag_last;
    assign o_tag.in_frame = r_tag_inside;
    assign o_tag.wt       = r_tag_wt;

    `ABS_ASSERT_NEXT(a_beats_back_to_back, i_clk, i_rst_n, r_tag_v && !r_tag_last, r_tag_v, "sample reads broke up mid-sample")
    `ABS_ASSERT_IMPL(a_beat_only_in_sample, i_clk, i_rst_n, r_beat != '0, r_busy && !is_write, "beat counter running outside a sample")

endmodule

// File: rtl/abs_accum.sv
`timescale 1ns / 1ps
// Weighted accumulation of neighbour reads, rounding, quantising and a small
// result queue with credit tracking for the sequencer. Depends on abs_pkg.
`include "affine_bilinear_sampler_macros.svh"
module abs_accum
    import abs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_quant_mode,
    input  logic                i_start,
    output logic                o_credit_ok,
    input  t_tag                i_tag,
    input  logic [PIX_BITS-1:0] i_rdata,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out                o_out_data
);

    logic [2:0][ACC_BITS-1:0] r_acc;
    logic                     r_acc_done;
    logic [2:0][7:0]          r_v;
    logic                     r_v_valid;
    t_out                     r_fifo [FIFO_DEPTH];
    logic [FIFO_BITS-1:0]     r_wr;
    logic [FIFO_BITS-1:0]     r_rd;
    logic [CNT_BITS-1:0]      r_fill;
    logic [CNT_BITS-1:0]      r_cnt;

    logic [2:0][7:0]          px;
    logic [2:0][24:0]         prod;
    logic [2:0][ACC_BITS-1:0] n_acc;
    logic [2:0][ACC_BITS-1:0] rsum;
    logic [2:0][7:0]          n_v;
    logic                     push;
    logic                     pop;
    t_out                     n_res;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            // Out-of-frame neighbours contribute nothing, whatever the store holds.
            px[c]    = i_tag.in_frame ? i_rdata[8*c +: 8] : 8'd0;
            prod[c]  = {17'd0, px[c]} * {8'd0, i_tag.wt};
            n_acc[c] = (i_tag.first ? '0 : r_acc[c]) + prod[c][ACC_BITS-1:0];
            rsum[c]  = r_acc[c] + ROUND_HALF;
            n_v[c]   = rsum[c][ACC_BITS-1:ACC_BITS-8];
        end
    end

    assign n_res.chan_red   = quantize(r_v[2], i_quant_mode);
    assign n_res.chan_green = quantize(r_v[1], i_quant_mode);
    assign n_res.chan_blue  = quantize(r_v[0], i_quant_mode);

    assign push        = r_v_valid;
    assign o_out_valid = (r_fill != '0);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_out_data  = r_fifo[r_rd];
    assign o_credit_ok = (r_cnt < CNT_BITS'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_done <= 1'b0;
            r_v_valid  <= 1'b0;
            r_wr       <= '0;
            r_rd       <= '0;
            r_fill     <= '0;
            r_cnt      <= '0;
        end else begin
            r_acc_done <= i_tag.valid && i_tag.last;
            r_v_valid  <= r_acc_done;
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_fill <= r_fill + CNT_BITS'(push) - CNT_BITS'(pop);
            r_cnt  <= r_cnt + CNT_BITS'(i_start) - CNT_BITS'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tag.valid) begin
            r_acc <= n_acc;
        end
        r_v <= n_v;
        if (push) begin
            r_fifo[r_wr] <= n_res;
        end
    end

    `ABS_ASSERT_NEVER(a_fill_within_credit, i_clk, i_rst_n, r_fill > r_cnt, "queued results exceed started samples")
    `ABS_ASSERT_NEVER(a_credit_bound, i_clk, i_rst_n, r_cnt > CNT_BITS'(FIFO_DEPTH), "more samples in flight than result slots")

endmodule

// File: rtl/affine_bilinear_sampler.sv
`timescale 1ns / 1ps
// Affine bilinear sampler top level: configuration registers, frame store
// and the front end, sequencer and accumulator. Depends on abs_pkg.
//
// A write request stores one RGB888 pixel with one write to the frame
// memory; a sample request maps an output coordinate through the affine
// registers to a 16.16 source position and bilinearly blends the four
// neighbours, reading them one a cycle through the single port of the frame
// memory, so a sample holds that port for all four reads, and writes go one
// a cycle while no sample holds the port or waits for a result slot. A
// sample's result passes four front-end stages, four reads, accumulate,
// round and quantise, and up to four results are held while the output is
// stalled. The frame store is not cleared by reset; sampling a pixel that
// was never written gives an unspecified value. Configuration is always
// ready and should be written only while no request is in flight.
module affine_bilinear_sampler
    import abs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg                  r_cfg;

    logic                  op_valid;
    logic                  op_ready;
    t_op                   op;
    logic                  credit_ok;
    logic                  start;
    logic                  ram_we;
    logic [STORE_BITS-1:0] ram_addr;
    logic [PIX_BITS-1:0]   ram_wdata;
    logic [PIX_BITS-1:0]   ram_rdata;
    t_tag                  tag;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ORIGIN_X:     r_cfg.origin_x     <= i_cfg_data;
                CFG_ORIGIN_Y:     r_cfg.origin_y     <= i_cfg_data;
                CFG_STEP_COS:     r_cfg.step_cos     <= i_cfg_data;
                CFG_STEP_SIN:     r_cfg.step_sin     <= i_cfg_data;
                CFG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data[DIM_BITS-1:0];
                CFG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data[DIM_BITS-1:0];
                CFG_QUANT_MODE:   r_cfg.quant_mode   <= i_cfg_data[0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    abs_xform u_xform (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_req      (i_in_data),
        .o_op_valid (op_valid),
        .i_op_ready (op_ready),
        .o_op       (op)
    );

    abs_fetch u_fetch (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_op_valid  (op_valid),
        .o_op_ready  (op_ready),
        .i_op        (op),
        .i_credit_ok (credit_ok),
        .o_start     (start),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .o_tag       (tag)
    );

    abs_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    abs_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_quant_mode (r_cfg.quant_mode),
        .i_start      (start),
        .o_credit_ok  (credit_ok),
        .i_tag        (tag),
        .i_rdata      (ram_rdata),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

// File: bench/affine_bilinear_sampler_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the affine bilinear sampler: directed table, then random phases.
// Depends on abs_pkg and the affine_bilinear_sampler RTL; reads no files.
module affine_bilinear_sampler_test;
    import abs_pkg::*;

    localparam logic [2:0]  CFG_UNUSED_INDEX = 3'd7;
    localparam int          RANDOM_PHASES    = 8;
    localparam int          PHASE_REQUESTS   = 75;
    localparam int          SETTLE_CYCLES    = 24;
    localparam int          WATCHDOG_LIMIT   = 3000;

    typedef struct {
        bit          is_reg;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        t_in         req;
        bit          has_want;
        t_out        want;
    } t_step;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in         in_req = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out        out_res;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    t_cfg        model_cfg = CFG_RESET;
    bit   [23:0] frame_shadow [bit [19:0]];
    logic [19:0] missing_neighbours [$];
    t_out        expected_pixels [$];
    t_step       plan [$];
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int          requests_taken = 0;
    int          quiet_cycles = 0;
    bit          mismatch_seen = 1'b0;

    affine_bilinear_sampler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Expected blend of one sample; also lists in-frame neighbours never written.
    function automatic t_out predict_sample(t_in req);
        logic [31:0] ox, oy, sx, sy, addr;
        logic [31:0] wt [4];
        logic [31:0] acc [3];
        logic [15:0] chan [3];
        logic [23:0] px;
        logic [7:0]  fx, fy, level;
        int          w, h, x0, y0, xx, yy, k, c;
        t_out        res;
        ox = 32'(req.out_x);
        oy = 32'(req.out_y);
        sx = model_cfg.origin_x + ox * model_cfg.step_cos - oy * model_cfg.step_sin;
        sy = model_cfg.origin_y + ox * model_cfg.step_sin + oy * model_cfg.step_cos;
        w = (model_cfg.frame_width > MAX_WIDTH) ? int'(MAX_WIDTH) : int'(model_cfg.frame_width);
        h = (model_cfg.frame_height > MAX_HEIGHT) ? int'(MAX_HEIGHT)
                                                  : int'(model_cfg.frame_height);
        x0 = int'($signed(sx[31:16]));
        y0 = int'($signed(sy[31:16]));
        fx = sx[15:8];
        fy = sy[15:8];
        wt[3] = 32'(fx) * 32'(fy);
        wt[1] = {16'd0, fx, 8'd0} - wt[3];
        wt[2] = {16'd0, fy, 8'd0} - wt[3];
        wt[0] = 32'd65536 - wt[1] - wt[2] - wt[3];
        acc = '{default: 32'd0};
        missing_neighbours.delete();
        for (k = 0; k < 4; k++) begin
            xx = x0 + (k & 1);
            yy = y0 + (k >> 1);
            if (xx >= 0 && yy >= 0 && xx < w && yy < h) begin
                addr = 32'(yy * w + xx) & 32'h000F_FFFF;
                if (frame_shadow.exists(addr[19:0])) begin
                    px = frame_shadow[addr[19:0]];
                end else begin
                    px = '0;
                    missing_neighbours.push_back(addr[19:0]);
                end
                acc[0] += 32'(px[23:16]) * wt[k];
                acc[1] += 32'(px[15:8]) * wt[k];
                acc[2] += 32'(px[7:0]) * wt[k];
            end
        end
        for (c = 0; c < 3; c++) begin
            level = 8'((acc[c] + 32'd32768) >> 16);
            if (model_cfg.quant_mode) begin
                chan[c] = 16'((32'(level) * 32'd16384 + 32'd127) / 32'd255);
            end else begin
                chan[c] = 16'(32'(level) * 32'd257 - 32'd32768);
            end
        end
        res.chan_red   = chan[0];
        res.chan_green = chan[1];
        res.chan_blue  = chan[2];
        return res;
    endfunction

    function automatic t_in random_request(t_func func);
        t_in r;
        r.func       = func;
        r.pixel_addr = 20'($urandom());
        r.red_in     = 8'($urandom());
        r.green_in   = 8'($urandom());
        r.blue_in    = 8'($urandom());
        r.out_x      = 8'($urandom());
        r.out_y      = 8'($urandom());
        return r;
    endfunction

    function automatic t_step reg_row(logic [2:0] idx, logic [31:0] val);
        t_step s;
        s = '{is_reg: 1'b1, reg_idx: idx, reg_val: val, req: '0, has_want: 1'b0, want: '0};
        return s;
    endfunction

    function automatic t_step write_row(logic [19:0] addr, logic [7:0] r, g, b);
        t_step s;
        s = reg_row('0, '0);
        s.is_reg = 1'b0;
        s.req = '{func: FUNC_WRITE, pixel_addr: addr, red_in: r, green_in: g, blue_in: b,
                  out_x: 8'hFF, out_y: 8'hFF};
        return s;
    endfunction

    function automatic t_step sample_row(logic [7:0] x, y);
        t_step s;
        s = reg_row('0, '0);
        s.is_reg = 1'b0;
        s.req = '{func: FUNC_SAMPLE, pixel_addr: 20'hFFFFF, red_in: 8'hFF, green_in: 8'hFF,
                  blue_in: 8'hFF, out_x: x, out_y: y};
        return s;
    endfunction

    function automatic t_step fixed_row(logic [7:0] x, y, int r, g, b);
        t_step s;
        s = sample_row(x, y);
        s.has_want = 1'b1;
        s.want = '{chan_red: 16'(r), chan_green: 16'(g), chan_blue: 16'(b)};
        return s;
    endfunction

    function automatic void check_channel(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, $signed(want), $signed(got));
            mismatch_seen = 1'b1;
        end
    endfunction

    // Offer one request, hold it until taken, then update the shadow frame or queue the
    // expected pixel.
    task automatic hand_over(input t_in req, input bit has_want, input t_out want);
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge clk); while (in_stall);
        requests_taken++;
        if (req.func == FUNC_WRITE) begin
            frame_shadow[req.pixel_addr] = {req.red_in, req.green_in, req.blue_in};
        end else begin
            expected_pixels.push_back(has_want ? want : predict_sample(req));
        end
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Write any unwritten in-frame neighbour first so no sample reads stale store contents.
    task automatic issue(input t_in req, input bit has_want, input t_out want);
        logic [19:0] gaps [$];
        t_in         fill;
        if (req.func == FUNC_SAMPLE) begin
            void'(predict_sample(req));
            gaps = missing_neighbours;
            foreach (gaps[i]) begin
                fill = random_request(FUNC_WRITE);
                fill.pixel_addr = gaps[i];
                hand_over(fill, 1'b0, '0);
            end
        end
        hand_over(req, has_want, want);
    endtask

    task automatic drain_requests();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Keep valid high when another write follows in the next cycle.
    task automatic write_register(input logic [2:0] idx, input logic [31:0] val, input bit more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (!more) begin
            cfg_valid <= 1'b0;
        end
        case (idx)
            CFG_ORIGIN_X:     model_cfg.origin_x     = val;
            CFG_ORIGIN_Y:     model_cfg.origin_y     = val;
            CFG_STEP_COS:     model_cfg.step_cos     = val;
            CFG_STEP_SIN:     model_cfg.step_sin     = val;
            CFG_FRAME_WIDTH:  model_cfg.frame_width  = val[DIM_BITS-1:0];
            CFG_FRAME_HEIGHT: model_cfg.frame_height = val[DIM_BITS-1:0];
            CFG_QUANT_MODE:   model_cfg.quant_mode   = val[0];
            default: ;
        endcase
    endtask

    task automatic program_phase(input int phase);
        logic [31:0] vals [8];
        logic [2:0]  idxs [8];
        logic [31:0] d;
        int          w, h, span, k;
        case (phase)
            0: begin
                w = 1024;
                h = 1024;
            end
            1: begin
                w = 1;
                h = 1;
            end
            2: begin
                w = $urandom_range(1025, 2047);
                h = $urandom_range(1025, 2047);
            end
            3: begin
                if ($urandom_range(1)) begin
                    w = 0;
                    h = $urandom_range(0, 2047);
                end else begin
                    w = $urandom_range(1, 2047);
                    h = 0;
                end
            end
            default: begin
                w = $urandom_range(1, 48);
                h = $urandom_range(1, 48);
            end
        endcase
        span = (w > h) ? w : h;
        span = (span > 1024) ? 1024 : ((span < 1) ? 1 : span);
        idxs = '{CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_STEP_COS, CFG_UNUSED_INDEX, CFG_STEP_SIN,
                 CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_QUANT_MODE};
        // Land most positions in or near the frame; one phase takes wild wrapping values.
        vals[0] = ((32'($urandom_range(0, span + 3)) - 32'd2) << 16)
                  | 32'($urandom_range(0, 65535));
        vals[1] = ((32'($urandom_range(0, span + 3)) - 32'd2) << 16)
                  | 32'($urandom_range(0, 65535));
        vals[2] = 32'($urandom_range(0, 1024 * span)) - 32'(512 * span);
        vals[3] = $urandom();
        vals[4] = 32'($urandom_range(0, 1024 * span)) - 32'(512 * span);
        if (phase == 5) begin
            vals[0] = $urandom();
            vals[1] = $urandom();
            vals[2] = $urandom();
            vals[4] = $urandom();
        end
        d = $urandom();
        d[DIM_BITS-1:0] = DIM_BITS'(w);
        vals[5] = d;
        d = $urandom();
        d[DIM_BITS-1:0] = DIM_BITS'(h);
        vals[6] = d;
        d = $urandom();
        d[0] = phase[0];
        vals[7] = d;
        for (k = 0; k < 8; k++) begin
            write_register(idxs[k], vals[k], k < 7);
        end
    endtask

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge clk) begin : check_pixels
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel red %0d green %0d blue %0d", $time,
                         out_res.chan_red, out_res.chan_green, out_res.chan_blue);
                mismatch_seen = 1'b1;
            end else begin
                want = expected_pixels.pop_front();
                check_channel("red", want.chan_red, out_res.chan_red);
                check_channel("green", want.chan_green, out_res.chan_green);
                check_channel("blue", want.chan_blue, out_res.chan_blue);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (rst_n) begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("affine_bilinear_sampler test failed");
            $finish;
        end
    end

    initial begin
        // Top-left pixel alone, then the far corner of a full frame through both
        // quantisers, the width clamp, a zero height and position extremes.
        plan.push_back(write_row(20'h00000, 8'hFF, 8'h00, 8'h80));
        plan.push_back(fixed_row(8'd0, 8'd0, 32767, -32768, 128));
        plan.push_back(write_row(20'hFFFFF, 8'h00, 8'hFF, 8'h01));
        plan.push_back(reg_row(CFG_ORIGIN_X, 32'h03FF_0000));
        plan.push_back(reg_row(CFG_ORIGIN_Y, 32'h03FF_0000));
        plan.push_back(fixed_row(8'd0, 8'd0, -32768, 32767, -32511));
        plan.push_back(reg_row(CFG_QUANT_MODE, 32'hFFFF_FFFF));
        plan.push_back(fixed_row(8'd0, 8'd0, 0, 16384, 64));
        plan.push_back(reg_row(CFG_FRAME_WIDTH, 32'h0000_07FF));
        plan.push_back(fixed_row(8'd0, 8'd0, 0, 16384, 64));
        plan.push_back(reg_row(CFG_FRAME_HEIGHT, 32'h0000_0000));
        plan.push_back(fixed_row(8'd0, 8'd0, 0, 0, 0));
        plan.push_back(reg_row(CFG_UNUSED_INDEX, 32'hFFFF_FFFF));
        plan.push_back(reg_row(CFG_FRAME_HEIGHT, 32'hFFFF_FC00));
        plan.push_back(reg_row(CFG_QUANT_MODE, 32'hFFFF_FFFE));
        plan.push_back(fixed_row(8'd0, 8'd0, -32768, 32767, -32511));
        plan.push_back(reg_row(CFG_ORIGIN_X, 32'h8000_0000));
        plan.push_back(reg_row(CFG_ORIGIN_Y, 32'h7FFF_FFFF));
        plan.push_back(fixed_row(8'd0, 8'd0, -32768, -32768, -32768));
        plan.push_back(reg_row(CFG_STEP_COS, 32'h7FFF_FFFF));
        plan.push_back(reg_row(CFG_STEP_SIN, 32'h8000_0000));
        plan.push_back(sample_row(8'd255, 8'd255));
        plan.push_back(reg_row(CFG_ORIGIN_X, 32'h0000_0000));
        plan.push_back(sample_row(8'd1, 8'd0));
        plan.push_back(sample_row(8'd0, 8'd1));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        sender_idle_pct    = 28;
        receiver_stall_pct = 28;
        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                if (i == 0 || !plan[i-1].is_reg) begin
                    drain_requests();
                end
                write_register(plan[i].reg_idx, plan[i].reg_val,
                               (i + 1 < plan.size()) && plan[i+1].is_reg);
            end else begin
                issue(plan[i].req, plan[i].has_want, plan[i].want);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            int goal;
            // Hold off until every pixel is back before touching the registers.
            drain_requests();
            program_phase(phase);
            case (phase % 4)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 88;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 88;
                end
                default: begin
                    sender_idle_pct    = 28;
                    receiver_stall_pct = 28;
                end
            endcase
            goal = requests_taken + PHASE_REQUESTS;
            while (requests_taken < goal) begin
                if ($urandom_range(99) < 15) begin
                    issue(random_request(FUNC_WRITE), 1'b0, '0);
                end else begin
                    issue(random_request(FUNC_SAMPLE), 1'b0, '0);
                end
            end
        end

        drain_requests();
        if (!mismatch_seen) begin
            $display("affine_bilinear_sampler test passed");
        end else begin
            $display("affine_bilinear_sampler test failed");
        end
        $finish;
    end

endmodule
